// ----- design/pwtx_pkg.sv -----
// ----------------------------------------------------------------------------
// pwtx_pkg: shared types and constants for the pulse-width wire transmitter
// Frame phase codes, register indexes and fixed frame constants.
// ----------------------------------------------------------------------------
package pwtx_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START_HI,
        PH_START_LO,
        PH_BIT_HI,
        PH_BIT_LO,
        PH_END
    } phase_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_LOW_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW_TICKS  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW_TICKS   = 2'd3;

    localparam logic [2:0] RESET_REPEAT_COUNT    = 3'd3;
    localparam logic [3:0] RESET_START_LOW_TICKS = 4'd4;
    localparam logic [3:0] RESET_ZERO_LOW_TICKS  = 4'd1;
    localparam logic [3:0] RESET_ONE_LOW_TICKS   = 4'd4;

    localparam logic [3:0] END_TICKS = 4'd4;
    localparam int         BYTE_W    = 8;

    typedef struct packed {
        logic line_level;
        logic line_driven;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } result_t;

endpackage

// ----- design/pulse_width_single_wire_tx.sv -----
// ----------------------------------------------------------------------------
// pulse_width_single_wire_tx: single-wire pulse-width byte transmitter
// Each tick item drives the wire for one tick; a send item latches a byte
// and starts a frame of start pulse, repeated bits and end pattern.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid / s_tready  tuser: command, tdata: data_byte
//  m_*       out   m_tvalid / m_tready  tdata: level, driven, busy, accepted;
//                                       tlast: frame_done
//  cfg_*     in    cfg_we               cfg_index, cfg_data
//
//  One item per cycle while no held result is left untaken; each item yields one result in the next cycle.
//  Frame state updates in the accept cycle; the result register holds it.
//  s_tready is high while the result register is empty or being taken.
//  Reset clears frame state, result valid and loads register defaults.
// ----------------------------------------------------------------------------
module pulse_width_single_wire_tx #(
    parameter int BITS_PER_WORD = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic [0:0]                        s_tuser,   // [0] command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [0] line_level,
                                                         // [1] line_driven,
                                                         // [2] busy_res,
                                                         // [3] accepted,
                                                         // [7:4] zero
    output logic                              m_tlast,   // frame_done
    input  logic                              cfg_we,
    input  logic [pwtx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pwtx_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pwtx_pkg::*;

    localparam int BP_W  = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;
    localparam int BPX_W = 5;
    localparam logic [BPX_W-1:0] BPW_X = BPX_W'(BITS_PER_WORD);

    logic [2:0]      repeat_count_reg;
    logic [3:0]      start_low_ticks_reg;
    logic [3:0]      zero_low_ticks_reg;
    logic [3:0]      one_low_ticks_reg;

    phase_t          phase_reg, phase_next;
    logic [3:0]      tick_count_reg, tick_count_next;
    logic [BP_W-1:0] bit_position_reg, bit_position_next;
    logic [2:0]      repeat_index_reg, repeat_index_next;
    logic [7:0]      held_byte_reg, held_byte_next;

    logic            out_valid_reg;
    result_t         out_data_reg, res;

    logic            in_accept;
    logic [3:0]      tick_inc;
    logic [3:0]      start_need, bit_need, repeat_need;
    logic [BPX_W-1:0] bp_ext, bp_inc;
    logic            cur_bit;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg.accepted, out_data_reg.busy_res,
                       out_data_reg.line_driven, out_data_reg.line_level};
    assign m_tlast  = out_data_reg.frame_done;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_count_reg    <= RESET_REPEAT_COUNT;
            start_low_ticks_reg <= RESET_START_LOW_TICKS;
            zero_low_ticks_reg  <= RESET_ZERO_LOW_TICKS;
            one_low_ticks_reg   <= RESET_ONE_LOW_TICKS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REPEAT_COUNT:    repeat_count_reg    <= cfg_data[2:0];
                REG_START_LOW_TICKS: start_low_ticks_reg <= cfg_data[3:0];
                REG_ZERO_LOW_TICKS:  zero_low_ticks_reg  <= cfg_data[3:0];
                REG_ONE_LOW_TICKS:   one_low_ticks_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign tick_inc    = tick_count_reg + 4'd1;
    assign bp_ext      = BPX_W'(bit_position_reg);
    assign bp_inc      = bp_ext + 5'd1;
    assign cur_bit     = (bp_ext < 5'd8) ? held_byte_reg[bp_ext[2:0]] : 1'b0;
    assign start_need  = (start_low_ticks_reg == 4'd0) ? 4'd1 : start_low_ticks_reg;
    assign bit_need    = cur_bit ?
                         ((one_low_ticks_reg == 4'd0) ? 4'd1 : one_low_ticks_reg) :
                         ((zero_low_ticks_reg == 4'd0) ? 4'd1 : zero_low_ticks_reg);
    assign repeat_need = (repeat_count_reg == 3'd0) ? 4'd1 : {1'b0, repeat_count_reg};

    // next frame state and result for one item
    always_comb
    begin
        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        bit_position_next = bit_position_reg;
        repeat_index_next = repeat_index_reg;
        held_byte_next    = held_byte_reg;
        res               = '0;

        if (s_tuser[0])
        begin
            if (phase_reg == PH_IDLE)
            begin
                held_byte_next    = s_tdata;
                phase_next        = PH_START_HI;
                tick_count_next   = '0;
                bit_position_next = '0;
                repeat_index_next = '0;
                res.accepted      = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE: ;
                PH_START_HI:
                begin
                    res.line_level  = 1'b1;
                    res.line_driven = 1'b1;
                    phase_next      = PH_START_LO;
                    tick_count_next = '0;
                end
                PH_START_LO:
                begin
                    res.line_driven = 1'b1;
                    tick_count_next = tick_inc;
                    if (tick_inc >= start_need || tick_inc == 4'd0)
                    begin
                        phase_next        = PH_BIT_HI;
                        tick_count_next   = '0;
                        bit_position_next = '0;
                        repeat_index_next = '0;
                    end
                end
                PH_BIT_HI:
                begin
                    res.line_level  = 1'b1;
                    res.line_driven = 1'b1;
                    phase_next      = PH_BIT_LO;
                    tick_count_next = '0;
                end
                PH_BIT_LO:
                begin
                    res.line_driven = 1'b1;
                    tick_count_next = tick_inc;
                    if (tick_inc >= bit_need || tick_inc == 4'd0)
                    begin
                        tick_count_next   = '0;
                        phase_next        = PH_BIT_HI;
                        bit_position_next = bp_inc[BP_W-1:0];
                        if (bp_inc >= BPW_X)
                        begin
                            bit_position_next = '0;
                            if ({1'b0, repeat_index_reg} + 4'd1 >= repeat_need)
                            begin
                                repeat_index_next = '0;
                                phase_next        = PH_END;
                            end
                            else
                            begin
                                repeat_index_next = repeat_index_reg + 3'd1;
                            end
                        end
                    end
                end
                PH_END:
                begin
                    res.line_driven = 1'b1;
                    res.line_level  = !tick_count_reg[0];
                    tick_count_next = tick_inc;
                    if (tick_inc >= END_TICKS)
                    begin
                        tick_count_next = '0;
                        phase_next      = PH_IDLE;
                        res.frame_done  = 1'b1;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
        res.busy_res = (phase_next != PH_IDLE);
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tick_count_reg   <= '0;
            bit_position_reg <= '0;
            repeat_index_reg <= '0;
            held_byte_reg    <= '0;
        end
        else if (in_accept)
        begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            bit_position_reg <= bit_position_next;
            repeat_index_reg <= repeat_index_next;
            held_byte_reg    <= held_byte_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= res;
        end
    end

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> tick_count_reg == 4'd0)
        else $error("tick count not zero while idle");

    a_send_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_tuser[0] && phase_reg == PH_IDLE |=> phase_reg == PH_START_HI)
        else $error("send item did not start frame");

    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[1] && !m_tdata[2] && phase_reg != PH_END)
        else $error("frame end result inconsistent");

    a_level_driven: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("high level on released line");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2] && !m_tdata[1])
        else $error("accepted send without busy");

endmodule
